// File: sv/md5_pkg.sv
// md5_pkg: shared types, constants and round tables for the md5 byte stream hasher
// no dependencies; imported by md5_block_buf, md5_round_unit and the top level
package md5_pkg;

  // sequencer states of the top level
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LOAD,
    ST_ROUND,
    ST_ADD,
    ST_DONE
  } md5_state_t;

  // padding phases: marker byte, zero fill, length bytes
  typedef enum logic [1:0] {
    PH_MARK,
    PH_ZERO,
    PH_LEN
  } md5_phase_t;

  // four md5 working or chaining words
  typedef struct packed {
    logic [31:0] d;
    logic [31:0] c;
    logic [31:0] b;
    logic [31:0] a;
  } md5_abcd_t;

  // byte write into the block buffer
  typedef struct packed {
    logic       en;
    logic [5:0] addr;
    logic [7:0] data;
  } md5_buf_wr_t;

  localparam logic [31:0] MD5_INIT_A = 32'h67452301;
  localparam logic [31:0] MD5_INIT_B = 32'hefcdab89;
  localparam logic [31:0] MD5_INIT_C = 32'h98badcfe;
  localparam logic [31:0] MD5_INIT_D = 32'h10325476;

  localparam logic [7:0] MD5_PAD_MARK = 8'h80;
  localparam logic [5:0] MD5_LEN_POS  = 6'd56;
  localparam logic [5:0] MD5_LAST_POS = 6'd63;

  localparam md5_abcd_t MD5_INIT = '{d: MD5_INIT_D, c: MD5_INIT_C, b: MD5_INIT_B,
                                     a: MD5_INIT_A};

  // additive constant of each round
  function automatic logic [31:0] md5_k(input logic [5:0] rnd);
    logic [31:0] k;
    begin
      unique case (rnd)
        6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
        6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
        6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
        6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
        6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
        6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
        6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
        6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
        6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
        6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
        6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
        6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
        6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
        6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
        6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
        6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
        6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
        6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
        6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
        6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
        6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
        6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
        6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
        6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
        6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
        6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
        6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
        6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
        6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
        6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
        6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
        6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
        default: k = '0;
      endcase
      return k;
    end
  endfunction

  // rotate amount of each round, repeating by quarter
  function automatic logic [4:0] md5_s(input logic [5:0] rnd);
    logic [4:0] s;
    begin
      unique case ({rnd[5:4], rnd[1:0]})
        4'b0000: s = 5'd7;   4'b0001: s = 5'd12;
        4'b0010: s = 5'd17;  4'b0011: s = 5'd22;
        4'b0100: s = 5'd5;   4'b0101: s = 5'd9;
        4'b0110: s = 5'd14;  4'b0111: s = 5'd20;
        4'b1000: s = 5'd4;   4'b1001: s = 5'd11;
        4'b1010: s = 5'd16;  4'b1011: s = 5'd23;
        4'b1100: s = 5'd6;   4'b1101: s = 5'd10;
        4'b1110: s = 5'd15;  4'b1111: s = 5'd21;
        default: s = '0;
      endcase
      return s;
    end
  endfunction

  // message word used by each round; multiples of 16 drop out modulo 16
  function automatic logic [3:0] md5_widx(input logic [5:0] rnd);
    logic [7:0] lo;
    logic [7:0] t;
    begin
      lo = {4'd0, rnd[3:0]};
      unique case (rnd[5:4])
        2'd0:    t = lo;
        2'd1:    t = 8'(lo * 8'd5 + 8'd1);
        2'd2:    t = 8'(lo * 8'd3 + 8'd5);
        2'd3:    t = 8'(lo * 8'd7);
        default: t = lo;
      endcase
      return t[3:0];
    end
  endfunction

endpackage

// File: sv/md5_block_buf.sv
// md5_block_buf: 64-byte message block held as 16 little-endian words
// byte-lane writes, one registered word read per cycle; uses md5_pkg
module md5_block_buf
  import md5_pkg::*;
(
  input  logic        clk,
  input  md5_buf_wr_t wr,
  input  logic [3:0]  rd_addr,
  output logic [31:0] rd_data
);

  logic [31:0] mem [16];
  logic [31:0] rd_data_r;

  // byte write into its lane of the addressed word
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr[5:2]][{wr.addr[1:0], 3'b000} +: 8] <= wr.data;
    end
  end

  // registered word read
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// File: sv/md5_round_unit.sv
// md5_round_unit: one md5 round step, shared across all 64 rounds of a block
// round function, constant and rotate chosen by the round number; uses md5_pkg
module md5_round_unit
  import md5_pkg::*;
(
  input  md5_abcd_t   cur,
  input  logic [31:0] word,
  input  logic [5:0]  rnd,
  output md5_abcd_t   nxt
);

  logic [31:0] f;
  logic [31:0] sum;
  logic [63:0] rot_dbl;

  // boolean function of the current quarter
  always_comb begin
    unique case (rnd[5:4])
      2'd0:    f = (cur.b & cur.c) | (~cur.b & cur.d);
      2'd1:    f = (cur.b & cur.d) | (cur.c & ~cur.d);
      2'd2:    f = cur.b ^ cur.c ^ cur.d;
      2'd3:    f = cur.c ^ (cur.b | ~cur.d);
      default: f = '0;
    endcase
  end

  // add, rotate left, add
  assign sum     = cur.a + f + md5_k(rnd) + word;
  assign rot_dbl = {sum, sum} << md5_s(rnd);

  assign nxt.a = cur.d;
  assign nxt.d = cur.c;
  assign nxt.c = cur.b;
  assign nxt.b = cur.b + rot_dbl[63:32];

endmodule

// File: sv/md5_byte_stream_hasher_unit.sv
// md5_byte_stream_hasher_unit: top level of the md5 byte stream hasher
// sequencer, length counter and chaining words; uses md5_pkg, md5_block_buf,
// md5_round_unit
//
// input channel: in_tdata carries one byte, in_tuser says the byte belongs to
// the message, in_tlast ends the message. output channel: one 128-bit digest
// item per message, digest byte 0 in out_tdata[7:0].
// an item that does not fill a block is taken in idle, ready for the next. the
// item that fills the 64-byte block starts a busy block pass: one word prefetch,
// 64 rounds through the single round unit (one round a cycle) and one chaining add.
// an end item then writes the padding one byte a cycle up to the end of the
// block (9 to 64 bytes); with fewer than 9 bytes free it writes 0 to 8 bytes,
// runs one extra block pass and writes 64 more padding bytes. the final block
// pass and the digest handover, which waits for a free output register, follow.
// in_tready is low throughout.
// the digest sits in an output register; the block goes back to accepting
// bytes while it waits, and only a later digest waits for out_tready.
// reset (rst_n low, synchronous) loads the initial chaining words, clears the
// byte count and bit length and drops out_tvalid.
module md5_byte_stream_hasher_unit
  import md5_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  // input item
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // data_byte[7:0]
  input  logic         in_tuser,   // byte_valid
  input  logic         in_tlast,   // end_of_message
  // result item
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata   // digest_low_half[63:0], digest_high_half[127:64]
);

  md5_state_t   state_r, state_nxt;
  md5_phase_t   phase_r, phase_nxt;
  logic [5:0]   fill_r, fill_nxt;
  logic [63:0]  len_r, len_nxt;
  md5_abcd_t    chain_r, chain_nxt;
  md5_abcd_t    work_r, work_nxt;
  logic [5:0]   rnd_r, rnd_nxt;
  logic         pad_on_r, pad_on_nxt;
  logic         fin_r, fin_nxt;
  logic         out_valid_r, out_valid_nxt;
  logic [127:0] out_data_r, out_data_nxt;

  md5_buf_wr_t  buf_wr;
  logic [3:0]   rd_addr;
  logic [31:0]  rd_word;
  md5_abcd_t    round_out;

  md5_block_buf u_buf (
    .clk     (clk),
    .wr      (buf_wr),
    .rd_addr (rd_addr),
    .rd_data (rd_word)
  );

  md5_round_unit u_round (
    .cur  (work_r),
    .word (rd_word),
    .rnd  (rnd_r),
    .nxt  (round_out)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= PH_MARK;
      fill_r      <= '0;
      len_r       <= '0;
      chain_r     <= MD5_INIT;
      rnd_r       <= '0;
      pad_on_r    <= 1'b0;
      fin_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      fill_r      <= fill_nxt;
      len_r       <= len_nxt;
      chain_r     <= chain_nxt;
      rnd_r       <= rnd_nxt;
      pad_on_r    <= pad_on_nxt;
      fin_r       <= fin_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    work_r     <= work_nxt;
    out_data_r <= out_data_nxt;
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    fill_nxt      = fill_r;
    len_nxt       = len_r;
    chain_nxt     = chain_r;
    work_nxt      = work_r;
    rnd_nxt       = rnd_r;
    pad_on_nxt    = pad_on_r;
    fin_nxt       = fin_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r;
    in_tready     = 1'b0;
    buf_wr        = '0;
    rd_addr       = md5_widx(6'(rnd_r + 6'd1));

    // digest taken by the receiver
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (in_tuser) begin
            buf_wr.en   = 1'b1;
            buf_wr.addr = fill_r;
            buf_wr.data = in_tdata;
            fill_nxt    = 6'(fill_r + 6'd1);
            len_nxt     = 64'(len_r + 64'd8);
          end
          if (in_tlast) begin
            pad_on_nxt = 1'b1;
            phase_nxt  = PH_MARK;
          end
          if (in_tuser && fill_r == MD5_LAST_POS) begin
            state_nxt = ST_LOAD;
          end else if (in_tlast) begin
            state_nxt = ST_PAD;
          end
        end
      end

      ST_PAD: begin
        buf_wr.en   = 1'b1;
        buf_wr.addr = fill_r;
        fill_nxt    = 6'(fill_r + 6'd1);
        unique case (phase_r)
          PH_MARK: begin
            buf_wr.data = MD5_PAD_MARK;
            phase_nxt   = PH_ZERO;
          end
          PH_ZERO: begin
            if (fill_r == MD5_LEN_POS) begin
              buf_wr.data = len_r[7:0];
              phase_nxt   = PH_LEN;
            end else begin
              buf_wr.data = '0;
            end
          end
          PH_LEN: begin
            buf_wr.data = len_r[{fill_r[2:0], 3'b000} +: 8];
            if (fill_r == MD5_LAST_POS) begin
              fin_nxt = 1'b1;
            end
          end
          default: buf_wr.data = '0;
        endcase
        if (fill_r == MD5_LAST_POS) begin
          state_nxt = ST_LOAD;
        end
      end

      // prefetch word for round 0 and load the working words
      ST_LOAD: begin
        rd_addr   = md5_widx(6'd0);
        work_nxt  = chain_r;
        rnd_nxt   = '0;
        state_nxt = ST_ROUND;
      end

      ST_ROUND: begin
        work_nxt = round_out;
        rnd_nxt  = 6'(rnd_r + 6'd1);
        if (rnd_r == MD5_LAST_POS) begin
          state_nxt = ST_ADD;
        end
      end

      // fold the block result into the chaining words
      ST_ADD: begin
        chain_nxt.a = chain_r.a + work_r.a;
        chain_nxt.b = chain_r.b + work_r.b;
        chain_nxt.c = chain_r.c + work_r.c;
        chain_nxt.d = chain_r.d + work_r.d;
        if (fin_r) begin
          state_nxt = ST_DONE;
        end else if (pad_on_r) begin
          state_nxt = ST_PAD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end

      // hand the digest over once the output register is free
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_data_nxt  = {chain_r.d, chain_r.c, chain_r.b, chain_r.a};
          out_valid_nxt = 1'b1;
          chain_nxt     = MD5_INIT;
          len_nxt       = '0;
          fill_nxt      = '0;
          pad_on_nxt    = 1'b0;
          fin_nxt       = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
